FILE: sv/sprb_pkg.sv
// Shared types, codes and constants for the serial pad reader bank port.
package sprb_pkg;

    // ROM address space in words
    localparam int ROM_ADDR_BITS = 26;
    localparam logic [25:0] ROM_ADDR_MASK = 26'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_PORT_WRITE = 2'd0;
    localparam logic [1:0] OP_PORT_READ  = 2'd1;
    localparam logic [1:0] OP_ROM_FETCH  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PLAYER_ONE_BIT = 2'd0;
    localparam logic [1:0] CFG_PLAYER_TWO_BIT = 2'd1;
    localparam logic [1:0] CFG_BANKED_MODE    = 2'd2;
    localparam logic [1:0] CFG_ROM_WORD_MASK  = 2'd3;

    // Reset values
    localparam logic [3:0]  PLAYER_ONE_BIT_RST  = 4'd10;
    localparam logic [3:0]  PLAYER_TWO_BIT_RST  = 4'd12;
    localparam logic        BANKED_MODE_RST     = 1'b1;
    localparam logic [25:0] ROM_WORD_MASK_RST   = 26'h1ffffff;
    localparam logic [7:0]  BUTTON_INDEX_RST    = 8'hff;
    localparam logic [15:0] PORT_LATCH_RST      = 16'h0000;
    localparam logic [8:0]  BANK_REGISTER_RST   = 9'h1e0;
    localparam logic [15:0] LAST_PORT_WRITE_RST = 16'h20e0;

    // Port bit masks
    localparam logic [15:0] SELECT_MASK     = 16'h0300;
    localparam logic [1:0]  SEL_RESET_INDEX = 2'b11;
    localparam logic [1:0]  SEL_NEXT_INDEX  = 2'b10;
    localparam logic [15:0] LATCH_READ_MASK = 16'hdf00;
    localparam logic [15:0] WRITE_READ_MASK = 16'h20ff;

    // Configuration register set
    typedef struct packed {
        logic [3:0]  player_one_bit;
        logic [3:0]  player_two_bit;
        logic        banked_mode;
        logic [25:0] rom_word_mask;
    } sprb_cfg_t;

    // One input item
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] data_word;
        logic [7:0]  player_one_buttons;
        logic [7:0]  player_two_buttons;
        logic [21:0] rom_offset;
    } sprb_item_t;

    // One result item
    typedef struct packed {
        logic [15:0] read_value;
        logic [25:0] rom_word_address;
    } sprb_result_t;

endpackage

FILE: sv/sprb_cfg.sv
// Configuration register file for the serial pad reader bank port.
module sprb_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [25:0]         wr_data,
    output sprb_pkg::sprb_cfg_t cfg
);
    import sprb_pkg::*;

    sprb_cfg_t cfg_reg;
    sprb_cfg_t cfg_next;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_PLAYER_ONE_BIT: cfg_next.player_one_bit = wr_data[3:0];
                CFG_PLAYER_TWO_BIT: cfg_next.player_two_bit = wr_data[3:0];
                CFG_BANKED_MODE:    cfg_next.banked_mode    = wr_data[0];
                CFG_ROM_WORD_MASK:  cfg_next.rom_word_mask  = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.player_one_bit <= PLAYER_ONE_BIT_RST;
            cfg_reg.player_two_bit <= PLAYER_TWO_BIT_RST;
            cfg_reg.banked_mode    <= BANKED_MODE_RST;
            cfg_reg.rom_word_mask  <= ROM_WORD_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/sprb_core.sv
// Pad protocol state, bank register and per-item result logic.
module sprb_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sprb_pkg::sprb_cfg_t    cfg,
    input  logic                   advance,
    input  sprb_pkg::sprb_item_t   item,
    output sprb_pkg::sprb_result_t result
);
    import sprb_pkg::*;

    logic [7:0]  button_index_reg;
    logic [7:0]  button_index_next;
    logic [15:0] port_latch_reg;
    logic [15:0] port_latch_next;
    logic [8:0]  bank_register_reg;
    logic [8:0]  bank_register_next;
    logic [15:0] last_port_write_reg;
    logic [15:0] last_port_write_next;

    logic [15:0] m1;
    logic [15:0] m2;
    logic [15:0] latch_base;
    logic [1:0]  sel;
    logic        index_valid;
    logic        p1_pressed;
    logic        p2_pressed;
    logic [15:0] merged_read;
    logic [25:0] rom_sum;

    // Player bit masks
    assign m1 = 16'h0001 << cfg.player_one_bit;
    assign m2 = 16'h0001 << cfg.player_two_bit;

    // Serial pad sampling at the current index
    assign latch_base  = (item.data_word & SELECT_MASK) | m1 | m2;
    assign sel         = latch_base[9:8];
    assign index_valid = (button_index_reg[7:3] == 5'd0);
    assign p1_pressed  = index_valid && item.player_one_buttons[button_index_reg[2:0]];
    assign p2_pressed  = index_valid && item.player_two_buttons[button_index_reg[2:0]];

    // Next state on a port write
    always_comb
    begin
        button_index_next    = button_index_reg;
        port_latch_next      = port_latch_reg;
        bank_register_next   = bank_register_reg;
        last_port_write_next = last_port_write_reg;
        if (item.opcode == OP_PORT_WRITE)
        begin
            case (sel)
                SEL_RESET_INDEX:
                begin
                    button_index_next = BUTTON_INDEX_RST;
                    port_latch_next   = latch_base;
                end
                SEL_NEXT_INDEX:
                begin
                    button_index_next = button_index_reg + 8'd1;
                    port_latch_next   = latch_base;
                end
                default:
                begin
                    port_latch_next = latch_base ^ (p1_pressed ? m1 : 16'h0000)
                                                 ^ (p2_pressed ? m2 : 16'h0000);
                end
            endcase
            bank_register_next[7:0] = item.data_word[7:0];
            bank_register_next[8]   = bank_register_reg[8]
                                      ^ (item.data_word[13] & ~last_port_write_reg[13]);
            last_port_write_next    = item.data_word;
        end
    end

    // Port readback and ROM address
    assign merged_read = ((port_latch_reg & (SELECT_MASK | m1 | m2)) & LATCH_READ_MASK)
                         | (last_port_write_reg & WRITE_READ_MASK);
    assign rom_sum     = {bank_register_reg, 17'd0} + {4'd0, item.rom_offset};

    always_comb
    begin
        result = '0;
        case (item.opcode)
            OP_PORT_READ:
                result.read_value = cfg.banked_mode ? merged_read : port_latch_reg;
            OP_ROM_FETCH:
                result.rom_word_address = rom_sum & cfg.rom_word_mask & ROM_ADDR_MASK;
            default:
                result = '0;
        endcase
    end

    // Update state when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_index_reg    <= BUTTON_INDEX_RST;
            port_latch_reg      <= PORT_LATCH_RST;
            bank_register_reg   <= BANK_REGISTER_RST;
            last_port_write_reg <= LAST_PORT_WRITE_RST;
        end
        else if (advance)
        begin
            button_index_reg    <= button_index_next;
            port_latch_reg      <= port_latch_next;
            bank_register_reg   <= bank_register_next;
            last_port_write_reg <= last_port_write_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A write with both select bits set parks the index
    a_index_park: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.opcode == OP_PORT_WRITE && sel == SEL_RESET_INDEX)
        |=> (button_index_reg == BUTTON_INDEX_RST))
        else $error("button index not parked");

    // State only moves on an advancing port write
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && item.opcode == OP_PORT_WRITE)
        |=> ($stable(port_latch_reg) && $stable(bank_register_reg)
             && $stable(last_port_write_reg) && $stable(button_index_reg)))
        else $error("state changed without a port write");
`endif

endmodule

FILE: sv/serial_pad_reader_bank_port_unit.sv
// Top level of the serial pad reader bank port: input and result registers.
//
// Input items arrive on the s_ stream: s_tuser carries the opcode (port write,
// port read, ROM fetch) and s_tdata the write data, both pads' buttons and the
// ROM word offset. Each item gives one result on the m_ stream: the port read
// value and the masked ROM word address, each zero when not asked for.
// Configuration registers are written over the cfg_ channel, which is always
// ready; write them only while no item is in flight.
// An accepted transaction sits in the input register, where the pad protocol,
// bank update and address add run; the result is registered into the result
// register when it has room, and m_tvalid rises with it. One transaction
// per cycle is sustained while m_tready is high, as state updates once per cycle.
// When m_tready is low the result holds, the input register still takes one
// more transaction, and then s_tready drops until the result drains.
// Reset clears both pipeline stages, returns the pad index, latch, bank and
// last written word to their startup values and restores the registers.
module serial_pad_reader_bank_port_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [25:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // data_word[15:0], player_one_buttons[23:16],
                                  // player_two_buttons[31:24], rom_offset[53:32], zero
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // read_value[15:0], rom_word_address[41:16], zero
);
    import sprb_pkg::*;

    sprb_cfg_t    cfg;
    sprb_item_t   item_reg;
    logic         item_valid_reg;
    sprb_result_t core_result;
    sprb_result_t result_reg;
    logic         result_valid_reg;
    logic         advance;
    logic         in_take;

    assign cfg_ready = 1'b1;

    sprb_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the input register into the result register when there is room
    assign advance  = item_valid_reg && (!result_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    sprb_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item_reg),
        .result  (core_result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode             <= s_tuser;
            item_reg.data_word          <= s_tdata[15:0];
            item_reg.player_one_buttons <= s_tdata[23:16];
            item_reg.player_two_buttons <= s_tdata[31:24];
            item_reg.rom_offset         <= s_tdata[53:32];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!result_valid_reg || m_tready)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {6'd0, result_reg.rom_word_address, result_reg.read_value};

`ifndef NO_ASSERTIONS
    // An empty input register always takes a transaction
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> s_tready)
        else $error("input refused while input register empty");

    // Both stages full and stalled must back-pressure
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && result_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted with both stages full");

    // A result never carries both a read value and a ROM address
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] == 16'd0 || m_tdata[41:16] == 26'd0))
        else $error("result carries both fields");
`endif

endmodule
